/* sv/vptw_pkg.sv */
// Package with shared types and constants for the vertex projection core.
`timescale 1ns / 1ps
`default_nettype none
package vptw_pkg;
   localparam int FRAC_BITS = 16;
   localparam int DIV_STEPS = 32 + FRAC_BITS + 1;
   localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC1,
      ST_MAC2,
      ST_DIV_SETUP,
      ST_DIV_RUN,
      ST_DIV_DONE,
      ST_VP_X,
      ST_VP_Y,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD    = 1'b0,
      MODE_PROJECT = 1'b1
   } mode_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

/* sv/vertex_project_to_window_core.sv */
// Top level of the vertex projection core: sequencer, shared multiplier and divider.
// Sequence: a load item writes matrix memory on acceptance; a project item runs two matrix
// passes on the shared 32x32 multiplier, three divisions (setup, 49 restoring steps,
// rounding), then viewport x, viewport y and output, which raises rsp_tvalid.
// A zero clip w skips the divisions and viewport steps.
// Throughput: one item at a time, ready only when idle with no result waiting.
// Reset (synchronous, active high) clears the sequencer, output valid and the viewport
// registers; matrix storage is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module vertex_project_to_window_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // mode, entry_index, entry_value, obj_x, obj_y, obj_z, 2 zero bits
   input  wire logic [135:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // ok, win_x, win_y, win_z, 7 zero bits
   output logic [103:0]       rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);
   import vptw_pkg::*;

   logic [31:0] mat_mem [0:31];
   state_type state_ff, state_in;
   logic signed [15:0] org_x_ff, org_y_ff;
   logic [14:0] vp_w_ff, vp_h_ff;

   logic signed [31:0] vin_ff [0:3];
   logic signed [31:0] vout_ff [0:3];
   logic signed [33:0] acc_ff;
   logic [1:0] row_ff, col_ff;
   logic [1:0] ax_ff;
   logic signed [31:0] mrd_ff;
   logic rd_ok_ff;
   logic [63:0] rem_ff;
   logic [DIV_STEPS-1:0] quo_ff;
   logic [31:0] den_ff;
   logic [5:0] cnt_ff;
   logic neg_ff;
   logic signed [31:0] h_ff [0:2];
   logic [103:0] out_ff;
   logic out_v_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [15:0] org_sel;
   logic signed [63:0] prod;
   logic signed [31:0] prod_r;
   logic signed [65:0] vp_sum;
   logic signed [31:0] dnum;
   logic [32:0] dmag;
   logic [65:0] q2;
   logic [33:0] qmag;
   logic signed [34:0] qs;
   logic signed [31:0] hval;

   logic acc_req;
   assign acc_req = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0; org_y_ff <= '0; vp_w_ff <= '0; vp_h_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: org_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: org_y_ff <= csr_wdata;
            CSR_WIDTH:    vp_w_ff <= csr_wdata[14:0];
            CSR_HEIGHT:   vp_h_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Matrix memory: one write port, one registered read port.
   logic [4:0] rd_addr;
   assign rd_addr = {(state_ff == ST_MAC2), col_ff, row_ff};
   always_ff @(posedge clock) begin
      if (acc_req && (req_tdata[0] == MODE_LOAD)) mat_mem[req_tdata[5:1]] <= req_tdata[37:6];
      mrd_ff <= mat_mem[rd_addr];
   end

   // Operand select for the shared multiplier: matrix passes or viewport scaling.
   always_comb begin
      case (state_ff)
         ST_VP_X: begin
            mul_a = h_ff[0];
            mul_b = $signed({17'd0, vp_w_ff});
            org_sel = org_x_ff;
         end
         ST_VP_Y: begin
            mul_a = h_ff[1];
            mul_b = $signed({17'd0, vp_h_ff});
            org_sel = org_y_ff;
         end
         default: begin
            mul_a = vin_ff[col_ff - 2'd1];
            mul_b = mrd_ff;
            org_sel = org_x_ff;
         end
      endcase
   end

   // Shared multiplier with Q rounding and saturation.
   assign prod = mul_a * mul_b;
   assign prod_r = sat32(66'(($signed({prod[63], prod}) + 65'(FX_ONE >>> 1)) >>> FRAC_BITS));
   assign vp_sum = 66'(prod) + (66'(org_sel) <<< FRAC_BITS);

   // Divider operands.
   assign dnum = vout_ff[ax_ff];
   assign dmag = dnum[31] ? (33'd0 - {dnum[31], dnum}) : {1'b0, dnum};

   // Round the quotient to nearest (ties away) and map it as (q + 1) / 2, taking -1..1 to 0..1.
   always_comb begin
      q2 = ((rem_ff << 1) >= {33'd0, den_ff}) ? 66'(quo_ff) + 66'd1 : 66'(quo_ff);
      qmag = (q2 > 66'h1_0000_0000) ? 34'h1_0000_0000 : q2[33:0];
      qs = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      hval = sat32(66'(($signed(sat32(66'(qs))) + FX_ONE + 32'sd1) >>> 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_v_ff && rsp_tready && (state_ff != ST_OUT)) out_v_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               row_ff <= '0; col_ff <= '0; acc_ff <= '0; rd_ok_ff <= 1'b0;
               if (acc_req && (req_tdata[0] == MODE_PROJECT)) begin
                  vin_ff[0] <= req_tdata[69:38];
                  vin_ff[1] <= req_tdata[101:70];
                  vin_ff[2] <= req_tdata[133:102];
                  vin_ff[3] <= FX_ONE;
               end
            end
            ST_MAC1, ST_MAC2: begin
               if (state_in != state_ff) begin
                  // The last product of row 3 closes the pass.
                  rd_ok_ff <= 1'b0; row_ff <= '0; col_ff <= '0; acc_ff <= '0;
                  if (state_ff == ST_MAC1) begin
                     vin_ff[0] <= vout_ff[0]; vin_ff[1] <= vout_ff[1];
                     vin_ff[2] <= vout_ff[2];
                     vin_ff[3] <= sat32(66'(acc_ff + prod_r));
                  end else begin
                     vout_ff[3] <= sat32(66'(acc_ff + prod_r));
                     ax_ff <= '0;
                  end
               end else begin
                  // Read issued this cycle; previous read's data is mrd_ff.
                  if (rd_ok_ff) begin
                     if (col_ff == 2'd0) begin
                        vout_ff[row_ff - 2'd1] <= sat32(66'(acc_ff + prod_r));
                        acc_ff <= '0;
                     end else acc_ff <= acc_ff + prod_r;
                  end
                  rd_ok_ff <= 1'b1;
                  col_ff <= col_ff + 2'd1;
                  if (col_ff == 2'd3) row_ff <= row_ff + 2'd1;
               end
            end
            ST_DIV_SETUP: begin
               rem_ff <= '0;
               quo_ff <= DIV_STEPS'(dmag) << FRAC_BITS;
               den_ff <= vout_ff[3][31] ? 32'(-vout_ff[3]) : vout_ff[3];
               neg_ff <= dnum[31] ^ vout_ff[3][31];
               cnt_ff <= '0;
            end
            ST_DIV_RUN: begin
               // One restoring step per cycle over the numerator bits.
               if ({rem_ff[62:0], quo_ff[DIV_STEPS-1]} >= {32'd0, den_ff}) begin
                  rem_ff <= {rem_ff[62:0], quo_ff[DIV_STEPS-1]} - {32'd0, den_ff};
                  quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[62:0], quo_ff[DIV_STEPS-1]};
                  quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
            end
            ST_DIV_DONE: begin
               h_ff[ax_ff] <= hval;
               ax_ff <= ax_ff + 2'd1;
            end
            ST_VP_X: h_ff[0] <= sat32(vp_sum);
            ST_VP_Y: h_ff[1] <= sat32(vp_sum);
            ST_OUT: begin
               out_v_ff <= 1'b1;
               if (vout_ff[3] == 32'sd0) out_ff <= '0;
               else out_ff <= {7'd0, h_ff[2], h_ff[1], h_ff[0], 1'b1};
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (acc_req && (req_tdata[0] == MODE_PROJECT)) state_in = ST_MAC1;
         ST_MAC1: if (rd_ok_ff && row_ff == 2'd0 && col_ff == 2'd0) state_in = ST_MAC2;
         ST_MAC2: if (rd_ok_ff && row_ff == 2'd0 && col_ff == 2'd0)
                     state_in = ST_DIV_SETUP;
         ST_DIV_SETUP: state_in = (vout_ff[3] == 32'sd0) ? ST_OUT : ST_DIV_RUN;
         ST_DIV_RUN: if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_DIV_DONE;
         ST_DIV_DONE: state_in = (ax_ff == 2'd2) ? ST_VP_X : ST_DIV_SETUP;
         ST_VP_X: state_in = ST_VP_Y;
         ST_VP_Y: state_in = ST_OUT;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Checks on sequencer behavior.
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("output moved");
   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_OUT) else $error("stray output");
endmodule
`default_nettype wire
